// ===== hdl/tseq_pkg.sv =====
// Shared types and constants of the time-sorted event queue.
package tseq_pkg;

  localparam int TIME_W = 32;
  localparam int KIND_W = 4;
  localparam int LEN_W  = 8;
  localparam int TAG_W  = 16;
  localparam int SEQ_W  = 5;
  localparam int MAX_RUN = 32;

  // request opcodes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_FETCH  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REPLY,
    S_FETCH
  } state_t;

  typedef struct packed {
    logic [TIME_W-1:0] stamp;
    logic [KIND_W-1:0] kind;
    logic [LEN_W-1:0]  length;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  // commands broadcast from the controller to every cell
  typedef struct packed {
    logic ins;
    logic clr;
    logic fetch;
    logic adv;
  } cell_ctrl_t;

  // what the chain shows at the fetch token
  typedef struct packed {
    logic              any;
    entry_t            cur;
    logic [TIME_W-1:0] next_time;
    logic              next_match;
  } sel_t;

endpackage

// ===== hdl/tseq_cell.sv =====
// One storage cell of the sorted chain: holds an event, shifts on insert, passes the fetch token.
module tseq_cell import tseq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cell_ctrl_t        cctl,
  input  logic [TIME_W-1:0] in_time,
  input  entry_t            in_entry,
  input  logic              prev_shift,
  input  logic              prev_valid,
  input  logic              prev_match_now,
  input  logic              prev_tok,
  input  entry_t            prev_entry,
  output logic              shift,
  output logic              valid,
  output logic              match_now,
  output logic              mat,
  output logic              tok,
  output entry_t            entry
);

  // compare the stored stamp against the request time
  always_comb begin
    shift     = !valid || (entry.stamp > in_time);
    match_now = valid && (entry.stamp == in_time);
  end

  // hold valid and token
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      tok   <= 1'b0;
    end else begin
      if (cctl.clr) begin
        valid <= 1'b0;
      end else if (cctl.ins && shift) begin
        valid <= prev_shift ? prev_valid : 1'b1;
      end
      if (cctl.fetch) begin
        tok <= match_now && !prev_match_now;
      end else if (cctl.adv) begin
        tok <= prev_tok && mat;
      end
    end
  end

  // take the neighbour's event or the new one; mark run membership on fetch
  always_ff @(posedge clk) begin
    if (cctl.ins && shift) begin
      entry <= prev_shift ? prev_entry : in_entry;
    end
    if (cctl.fetch) begin
      mat <= match_now;
    end
  end

endmodule

// ===== hdl/tseq_ctrl.sv =====
// Request sequencer and result register of the time-sorted event queue.
module tseq_ctrl import tseq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        op,
  input  logic              full,
  input  sel_t              sel,
  output cell_ctrl_t        cctl,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              status,
  output logic              has_event,
  output logic [TIME_W-1:0] out_time,
  output logic [KIND_W-1:0] out_kind,
  output logic [LEN_W-1:0]  out_length,
  output logic [TAG_W-1:0]  out_tag,
  output logic [SEQ_W-1:0]  sequence_number,
  output logic [TIME_W-1:0] next_time,
  output logic              last
);

  state_t             state, state_next;
  logic [SEQ_W-1:0]   seq;
  logic               status_hold;
  logic               accept;
  logic               out_free;
  logic               run_end;
  logic               load;
  logic               res_status;
  logic               res_has;
  entry_t             res_entry;
  logic [SEQ_W-1:0]   res_seq;
  logic [TIME_W-1:0]  res_next;
  logic               res_last;

  assign out_free = !out_valid || out_ready;
  assign run_end  = !sel.any || !sel.next_match || (seq == SEQ_W'(MAX_RUN - 1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (op == OP_FETCH) ? S_FETCH : S_REPLY;
        end
      end
      S_REPLY: begin
        if (out_free) state_next = S_IDLE;
      end
      S_FETCH: begin
        if (out_free && run_end) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // handshake, cell commands and result values
  always_comb begin
    in_ready   = (state == S_IDLE);
    accept     = in_valid && in_ready;
    cctl.ins   = accept && (op == OP_INSERT) && !full;
    cctl.clr   = accept && (op == OP_CLEAR);
    cctl.fetch = accept && (op == OP_FETCH);
    cctl.adv   = 1'b0;
    load       = 1'b0;
    res_status = 1'b0;
    res_has    = 1'b0;
    res_entry  = '0;
    res_seq    = '0;
    res_next   = '0;
    res_last   = 1'b0;
    unique case (state)
      S_IDLE: begin
      end
      S_REPLY: begin
        load       = out_free;
        res_status = status_hold;
        res_last   = 1'b1;
      end
      S_FETCH: begin
        load     = out_free;
        cctl.adv = out_free && !run_end;
        res_last = run_end;
        if (sel.any) begin
          res_has   = 1'b1;
          res_entry = sel.cur;
          res_seq   = seq;
          res_next  = run_end ? sel.next_time : '0;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      seq       <= '0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        seq <= '0;
      end else if (cctl.adv) begin
        seq <= seq + 1'b1;
      end
    end
  end

  // result register and latched insert status
  always_ff @(posedge clk) begin
    if (accept) begin
      status_hold <= (op == OP_INSERT) && full;
    end
    if (load) begin
      status          <= res_status;
      has_event       <= res_has;
      out_time        <= res_entry.stamp;
      out_kind        <= res_entry.kind;
      out_length      <= res_entry.length;
      out_tag         <= res_entry.tag;
      sequence_number <= res_seq;
      next_time       <= res_next;
      last            <= res_last;
    end
  end

endmodule

// ===== hdl/time_sorted_event_queue.sv =====
// Time-sorted event queue: top level with the cell chain and token select.
//
// Requests arrive on in_valid/in_ready with op, event_time, event_kind,
// payload_length and payload_tag; results leave on out_valid/out_ready.
// Insert places the event behind all stored events of equal or smaller
// time; on a full queue it returns status 1 and stores nothing. Fetch
// returns up to MAX_RUN consecutive events at the asked time, numbered from zero,
// with next_time and last on the final result; no match gives one empty
// result. Clear empties the queue. Every request ends in a result with last.
// Insert, clear and unused opcodes: the request moves the sequencer to S_REPLY,
// which loads the result register once it is free; the next request is taken
// when the sequencer is back in S_IDLE. Fetch: the request sets the token in the
// first matching cell, then S_FETCH loads one result per cycle while the receiver
// takes them, the token walking the chain one cell per result.
// Reset empties the queue and drops any pending result. A stalled receiver
// holds the result register; a new request is still taken while one waits.
module time_sorted_event_queue import tseq_pkg::*; #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        op,
  input  logic [TIME_W-1:0] event_time,
  input  logic [KIND_W-1:0] event_kind,
  input  logic [LEN_W-1:0]  payload_length,
  input  logic [TAG_W-1:0]  payload_tag,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              status,
  output logic              has_event,
  output logic [TIME_W-1:0] out_time,
  output logic [KIND_W-1:0] out_kind,
  output logic [LEN_W-1:0]  out_length,
  output logic [TAG_W-1:0]  out_tag,
  output logic [SEQ_W-1:0]  sequence_number,
  output logic [TIME_W-1:0] next_time,
  output logic              last
);

  cell_ctrl_t             cctl;
  sel_t                   sel;
  entry_t                 in_entry;
  logic [QUEUE_DEPTH-1:0] shift;
  logic [QUEUE_DEPTH-1:0] valid;
  logic [QUEUE_DEPTH-1:0] match_now;
  logic [QUEUE_DEPTH-1:0] mat;
  logic [QUEUE_DEPTH-1:0] tok;
  logic [QUEUE_DEPTH-1:0] order_ok;
  entry_t                 entry [QUEUE_DEPTH];

  assign in_entry = '{stamp: event_time, kind: event_kind, length: payload_length,
                      tag: payload_tag};

  // chain of cells, lowest time at cell zero
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      tseq_cell u_cell (
        .clk            (clk),
        .rst            (rst),
        .cctl           (cctl),
        .in_time        (event_time),
        .in_entry       (in_entry),
        .prev_shift     (1'b0),
        .prev_valid     (1'b0),
        .prev_match_now (1'b0),
        .prev_tok       (1'b0),
        .prev_entry     (in_entry),
        .shift          (shift[i]),
        .valid          (valid[i]),
        .match_now      (match_now[i]),
        .mat            (mat[i]),
        .tok            (tok[i]),
        .entry          (entry[i])
      );
      assign order_ok[i] = 1'b1;
    end else begin : g_body
      tseq_cell u_cell (
        .clk            (clk),
        .rst            (rst),
        .cctl           (cctl),
        .in_time        (event_time),
        .in_entry       (in_entry),
        .prev_shift     (shift[i-1]),
        .prev_valid     (valid[i-1]),
        .prev_match_now (match_now[i-1]),
        .prev_tok       (tok[i-1]),
        .prev_entry     (entry[i-1]),
        .shift          (shift[i]),
        .valid          (valid[i]),
        .match_now      (match_now[i]),
        .mat            (mat[i]),
        .tok            (tok[i]),
        .entry          (entry[i])
      );
      assign order_ok[i] = !valid[i] || (entry[i-1].stamp <= entry[i].stamp);
    end
  end

  // select the token cell and the cell behind it
  always_comb begin
    sel = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      sel.any = sel.any | tok[i];
      sel.cur = sel.cur | (entry[i] & {$bits(entry_t){tok[i]}});
    end
    for (int i = 1; i < QUEUE_DEPTH; i++) begin
      sel.next_time  = sel.next_time |
                       (entry[i].stamp & {TIME_W{tok[i-1] & valid[i]}});
      sel.next_match = sel.next_match | (tok[i-1] & mat[i]);
    end
  end

  tseq_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .op              (op),
    .full            (valid[QUEUE_DEPTH-1]),
    .sel             (sel),
    .cctl            (cctl),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .has_event       (has_event),
    .out_time        (out_time),
    .out_kind        (out_kind),
    .out_length      (out_length),
    .out_tag         (out_tag),
    .sequence_number (sequence_number),
    .next_time       (next_time),
    .last            (last)
  );

`ifndef SYNTHESIS
  // at most one cell carries the fetch token
  a_tok_onehot: assert property (@(posedge clk) disable iff (rst) $onehot0(tok))
    else $error("fetch token held by more than one cell");

  // stored events form an unbroken prefix of the chain
  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    (valid & ~{valid[QUEUE_DEPTH-2:0], 1'b1}) == '0)
    else $error("gap in the stored events");

  // stored events stay in ascending time order
  a_sorted: assert property (@(posedge clk) disable iff (rst) &order_ok)
    else $error("stored events out of time order");

  // the token advances only into a cell of the current run
  a_tok_in_run: assert property (@(posedge clk) disable iff (rst)
    cctl.adv |=> ((tok & ~mat) == '0))
    else $error("token left the matching run");
`endif

endmodule

// ===== dv/tb_time_sorted_event_queue.sv =====
// Randomised self-checking testbench for the time-sorted event queue.
module tb_time_sorted_event_queue;
  import tseq_pkg::*;

  localparam int QUEUE_DEPTH  = 32;
  localparam int RANDOM_ITEMS = 300;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 20;
  localparam int REPORT_MAX   = 10;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic [TIME_W-1:0] stamp;
    logic [KIND_W-1:0] kind;
    logic [LEN_W-1:0]  length;
    logic [TAG_W-1:0]  tag;
  } request_t;

  typedef struct packed {
    logic              status;
    logic              has_event;
    logic [TIME_W-1:0] stamp;
    logic [KIND_W-1:0] kind;
    logic [LEN_W-1:0]  length;
    logic [TAG_W-1:0]  tag;
    logic [SEQ_W-1:0]  seq;
    logic [TIME_W-1:0] next_time;
    logic              last;
  } event_reply_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_RANDOM,
    RX_PERIODIC,
    RX_SPARSE
  } rx_mode_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        op = OP_INSERT;
  logic [TIME_W-1:0] event_time = '0;
  logic [KIND_W-1:0] event_kind = '0;
  logic [LEN_W-1:0]  payload_length = '0;
  logic [TAG_W-1:0]  payload_tag = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              status;
  logic              has_event;
  logic [TIME_W-1:0] out_time;
  logic [KIND_W-1:0] out_kind;
  logic [LEN_W-1:0]  out_length;
  logic [TAG_W-1:0]  out_tag;
  logic [SEQ_W-1:0]  sequence_number;
  logic [TIME_W-1:0] next_time;
  logic              last;

  // stimulus backlog, shadow of the stored events, predicted replies
  request_t     request_backlog [$];
  request_t     live_request;
  entry_t       held_events [QUEUE_DEPTH];
  int           held_count = 0;
  event_reply_t event_replies [$];

  int       mismatch_count = 0;
  int       cycle_count = 0;
  int       burst_left = 0;
  int       gap_left = 0;
  rx_mode_t ready_mode = RX_OPEN;
  int       mode_cycles = 0;
  int       random_count = 0;

  time_sorted_event_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .op              (op),
    .event_time      (event_time),
    .event_kind      (event_kind),
    .payload_length  (payload_length),
    .payload_tag     (payload_tag),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .has_event       (has_event),
    .out_time        (out_time),
    .out_kind        (out_kind),
    .out_length      (out_length),
    .out_tag         (out_tag),
    .sequence_number (sequence_number),
    .next_time       (next_time),
    .last            (last)
  );

  always #4 clk = ~clk;

  // Update the shadow queue for one accepted request and queue its replies
  function automatic void apply_request(request_t req);
    event_reply_t rep;
    int pos;
    int run;
    int i;
    rep = '0;
    rep.last = 1'b1;
    case (req.op)
      OP_INSERT: begin
        if (held_count >= QUEUE_DEPTH) begin
          rep.status = 1'b1;
        end else begin
          pos = 0;
          while (pos < held_count && held_events[pos].stamp <= req.stamp) pos++;
          for (i = held_count; i > pos; i--) held_events[i] = held_events[i-1];
          held_events[pos] = '{stamp: req.stamp, kind: req.kind, length: req.length,
                               tag: req.tag};
          held_count++;
        end
        event_replies.push_back(rep);
      end
      OP_FETCH: begin
        pos = 0;
        while (pos < held_count && held_events[pos].stamp != req.stamp) pos++;
        if (pos >= held_count) begin
          event_replies.push_back(rep);
        end else begin
          run = 0;
          while (pos < held_count && held_events[pos].stamp == req.stamp && run < MAX_RUN) begin
            rep = '0;
            rep.has_event = 1'b1;
            rep.stamp     = held_events[pos].stamp;
            rep.kind      = held_events[pos].kind;
            rep.length    = held_events[pos].length;
            rep.tag       = held_events[pos].tag;
            rep.seq       = run[SEQ_W-1:0];
            run++;
            pos++;
            // close the run on its final event
            if (!(pos < held_count && held_events[pos].stamp == req.stamp && run < MAX_RUN))
            begin
              rep.next_time = (pos < held_count) ? held_events[pos].stamp : '0;
              rep.last = 1'b1;
            end
            event_replies.push_back(rep);
          end
        end
      end
      OP_CLEAR: begin
        held_count = 0;
        event_replies.push_back(rep);
      end
      default: event_replies.push_back(rep);
    endcase
  endfunction

  function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("%0t: %s expected %0h got %0h", $time, what, want, got);
  endfunction

  // Compare one accepted result with the oldest prediction
  function automatic void check_reply();
    event_reply_t want;
    if (event_replies.size() == 0) begin
      note_mismatch("result with nothing pending, out_time", '0, out_time);
      return;
    end
    want = event_replies.pop_front();
    if (want.status !== status) note_mismatch("status", 32'(want.status), 32'(status));
    if (want.has_event !== has_event)
      note_mismatch("has_event", 32'(want.has_event), 32'(has_event));
    if (want.stamp !== out_time) note_mismatch("out_time", want.stamp, out_time);
    if (want.kind !== out_kind) note_mismatch("out_kind", 32'(want.kind), 32'(out_kind));
    if (want.length !== out_length)
      note_mismatch("out_length", 32'(want.length), 32'(out_length));
    if (want.tag !== out_tag) note_mismatch("out_tag", 32'(want.tag), 32'(out_tag));
    if (want.seq !== sequence_number)
      note_mismatch("sequence_number", 32'(want.seq), 32'(sequence_number));
    if (want.next_time !== next_time) note_mismatch("next_time", want.next_time, next_time);
    if (want.last !== last) note_mismatch("last", 32'(want.last), 32'(last));
  endfunction

  task automatic push_request(logic [1:0] opc, logic [TIME_W-1:0] stamp,
                              logic [KIND_W-1:0] kind, logic [LEN_W-1:0] length,
                              logic [TAG_W-1:0] tag);
    request_backlog.push_back('{op: opc, stamp: stamp, kind: kind, length: length, tag: tag});
  endtask

  // Queue a request with random payload; ignored opcodes do not count
  task automatic push_random(logic [1:0] opc, logic [TIME_W-1:0] stamp);
    push_request(opc, stamp, KIND_W'($urandom()), LEN_W'($urandom()), TAG_W'($urandom()));
    if (opc != OP_UNUSED) random_count++;
  endtask

  function automatic logic [TIME_W-1:0] draw_stamp();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return TIME_W'($urandom_range(0, 15));
      default: return TIME_W'($urandom());
    endcase
  endfunction

  // Cycle count and watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[time_sorted_event_queue] ERROR");
      $finish;
    end
  end

  // Driver: present requests in bursts, predict on acceptance
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) apply_request(live_request);
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (request_backlog.size() != 0) begin
          live_request = request_backlog.pop_front();
          op             <= live_request.op;
          event_time     <= live_request.stamp;
          event_kind     <= live_request.kind;
          payload_length <= live_request.length;
          payload_tag    <= live_request.tag;
          in_valid       <= 1'b1;
          // end of burst: pick the next burst and the gap before it
          if (burst_left <= 1) begin
            burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 6);
            gap_left   <= ($urandom_range(0, 5) == 0) ? $urandom_range(6, 15)
                                                      : $urandom_range(0, 3);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check results and stall the result side on a pattern of its own
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_reply();
      if (mode_cycles == 0) begin
        ready_mode  <= rx_mode_t'($urandom_range(0, 3));
        mode_cycles <= $urandom_range(20, 80);
      end else begin
        mode_cycles <= mode_cycles - 1;
      end
      case (ready_mode)
        RX_OPEN:     out_ready <= 1'b1;
        RX_RANDOM:   out_ready <= ($urandom_range(0, 9) < 7);
        RX_PERIODIC: out_ready <= (cycle_count % 4 == 0);
        default:     out_ready <= ($urandom_range(0, 11) == 0);
      endcase
    end
  end

  initial begin
    logic [TIME_W-1:0] stamp_pool [$];
    int phase;
    int pool_size;
    int count;
    int pick;
    int i;
    bit first_phase;

    // Directed: empty queue, extremes, ties, runs, misses, unused opcode
    push_request(OP_FETCH,  '0, '0, '0, '0);
    push_request(OP_CLEAR,  '1, '1, '1, '1);
    push_request(OP_UNUSED, '1, '1, '1, '1);
    push_request(OP_INSERT, '1, '1, '1, '1);
    push_request(OP_INSERT, '0, '0, '0, '0);
    push_request(OP_INSERT, 32'd100, 4'd5, 8'd10, 16'h1111);
    push_request(OP_INSERT, 32'd100, 4'd6, 8'd20, 16'h2222);
    push_request(OP_INSERT, 32'd50,  4'd3, 8'd30, 16'h3333);
    push_request(OP_INSERT, 32'd100, 4'd7, 8'd40, 16'h4444);
    push_request(OP_FETCH,  32'd100, '0, '0, '0);
    push_request(OP_FETCH,  '0, '0, '0, '0);
    push_request(OP_FETCH,  '1, '0, '0, '0);
    push_request(OP_FETCH,  32'd50, '1, '1, '1);
    push_request(OP_FETCH,  32'd77, '0, '0, '0);
    push_request(OP_UNUSED, 32'd100, 4'd9, 8'd9, 16'h9999);
    push_request(OP_FETCH,  32'd100, '0, '0, '0);
    push_request(OP_CLEAR,  '0, '0, '0, '0);
    push_request(OP_FETCH,  32'd100, '0, '0, '0);
    push_request(OP_INSERT, 32'hAAAA_5555, 4'hA, 8'h55, 16'hA5A5);
    push_request(OP_FETCH,  32'hAAAA_5555, '0, '0, '0);

    // Random phases; the first one fills the queue to overflow
    first_phase = 1'b1;
    while (random_count < RANDOM_ITEMS) begin
      phase = first_phase ? 0 : $urandom_range(0, 9);
      first_phase = 1'b0;
      stamp_pool.delete();
      if (phase <= 1) begin
        // fill from empty with few distinct times, overflow, then read back
        pool_size = $urandom_range(1, 3);
        for (i = 0; i < pool_size; i++) stamp_pool.push_back(draw_stamp());
        push_random(OP_CLEAR, draw_stamp());
        count = QUEUE_DEPTH + $urandom_range(1, 3);
        for (i = 0; i < count; i++)
          push_random(OP_INSERT, stamp_pool[$urandom_range(0, pool_size - 1)]);
        for (i = 0; i < pool_size; i++) push_random(OP_FETCH, stamp_pool[i]);
        push_random(OP_FETCH, draw_stamp());
        push_random(OP_UNUSED, draw_stamp());
      end else if (phase <= 7) begin
        // mixed traffic over a small pool of times so fetches mostly hit
        pool_size = $urandom_range(2, 5);
        for (i = 0; i < pool_size; i++) stamp_pool.push_back(draw_stamp());
        count = $urandom_range(5, 15);
        for (i = 0; i < count; i++) begin
          pick = $urandom_range(0, 19);
          if (pick < 11)
            push_random(OP_INSERT, stamp_pool[$urandom_range(0, pool_size - 1)]);
          else if (pick < 18)
            push_random(OP_FETCH, ($urandom_range(0, 4) == 0) ? draw_stamp()
                                  : stamp_pool[$urandom_range(0, pool_size - 1)]);
          else if (pick == 18)
            push_random(OP_CLEAR, draw_stamp());
          else
            push_random(OP_UNUSED, draw_stamp());
        end
      end else begin
        // noise: any opcode, any fields
        count = $urandom_range(3, 8);
        for (i = 0; i < count; i++) push_random(2'($urandom_range(0, 3)), TIME_W'($urandom()));
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Drain: all requests taken and every predicted result seen
    while (request_backlog.size() != 0 || in_valid || event_replies.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && event_replies.size() == 0) begin
      $display("[time_sorted_event_queue] OK");
    end else begin
      $display("[time_sorted_event_queue] ERROR");
    end
    $finish;
  end

endmodule

// ===== time_sorted_event_queue.f =====
hdl/tseq_pkg.sv
hdl/tseq_cell.sv
hdl/tseq_ctrl.sv
hdl/time_sorted_event_queue.sv
dv/tb_time_sorted_event_queue.sv
